// File: rtl/assert_macros.svh
// Assertion macros shared by the cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define SALC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true
`define SALC_NEVER(label, expr, msg) \
   `SALC_ASSERT(label, !(expr), msg)

`endif

// File: rtl/salc_pkg.sv
// Types, constants and helpers for the size-aware LRU cache
package salc_pkg;

   localparam int unsigned ENTRIES    = 64;
   localparam int unsigned KEY_BITS   = 32;
   localparam int unsigned SLOT_BITS  = $clog2(ENTRIES);
   localparam int unsigned COUNT_BITS = $clog2(ENTRIES + 1);

   localparam logic [2:0] OP_ACCESS = 3'd0;
   localparam logic [2:0] OP_TOUCH  = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_EVICT  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic LINK_NEWER = 1'b0;
   localparam logic LINK_OLDER = 1'b1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] key;
      logic [31:0] entry_size;
      logic [6:0]  evict_count;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        hit;
      logic        inserted;
      logic [6:0]  evicted_total;
      logic [31:0] used_size;
      logic [31:0] access_total;
      logic [31:0] hit_total;
      logic [31:0] fault_total;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [31:0]         size;
   } entry_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] newer;
      logic [SLOT_BITS-1:0] older;
   } link_type;

   // one pending read-modify-write of a link field
   typedef struct packed {
      logic                 valid;
      logic [SLOT_BITS-1:0] slot;
      logic                 sel;
      logic [SLOT_BITS-1:0] value;
   } link_upd_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

// File: rtl/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module salc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/size_aware_lru_cache.sv
// A counter reset or a rejected request goes straight to the response; an evict of zero checks its count first.
// A key lookup scans the key memory at one slot per cycle;
// each relink is a read and a write of the link memory, each eviction an unlink and a drop,
// and an inserting miss adds a scan for a free slot.
// One request at a time; the next is taken once the result is registered.
// Synchronous reset clears valid bits, list ends, count, size and counters.
`include "assert_macros.svh"

module size_aware_lru_cache (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  salc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output salc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   import salc_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_SCAN   = 12'b0000_0000_0010,
      ST_UNL_RD = 12'b0000_0000_0100,
      ST_UNL_DO = 12'b0000_0000_1000,
      ST_POST   = 12'b0000_0001_0000,
      ST_LNK_RD = 12'b0000_0010_0000,
      ST_LNK_WR = 12'b0000_0100_0000,
      ST_EVICT  = 12'b0000_1000_0000,
      ST_EVICT3 = 12'b0001_0000_0000,
      ST_FREE   = 12'b0010_0000_0000,
      ST_INSERT = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [31:0]           capacity_ff, capacity_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [SLOT_BITS-1:0]  newest_ff, newest_in, oldest_ff, oldest_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [31:0]           used_ff, used_in;
   logic [31:0]           acc_ff, acc_in, hits_ff, hits_in, faults_ff, faults_in;

   logic [2:0]            op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [31:0]           size_ff, size_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic                  ok_ff, ok_in, hit_ff, hit_in, ins_ff, ins_in;
   logic [6:0]            ev_ff, ev_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_BITS-1:0]  last_ff, last_in;
   logic [SLOT_BITS-1:0]  cur_ff, cur_in;
   logic                  drop_ff, drop_in;
   link_upd_type          upd0_ff, upd0_in, upd1_ff, upd1_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  ent_we;
   logic [SLOT_BITS-1:0]  ent_waddr, ent_raddr;
   entry_type             ent_wdata, ent_rdata;
   logic                  lnk_we;
   logic [SLOT_BITS-1:0]  lnk_waddr, lnk_raddr;
   link_type              lnk_wdata, lnk_rdata;

   logic                  fits;
   logic                  match;

   salc_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   salc_ram #(.WIDTH($bits(link_type)), .DEPTH(ENTRIES)) u_link_ram (
      .clock   (clock),
      .wr_en   (lnk_we),
      .wr_addr (lnk_waddr),
      .wr_data (lnk_wdata),
      .rd_addr (lnk_raddr),
      .rd_data (lnk_rdata)
   );

   assign fits  = (used_ff <= capacity_ff) && ((capacity_ff - used_ff) >= size_ff);
   assign match = pend_ff && valid_ff[last_ff] && (ent_rdata.key == key_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;
      valid_in    = valid_ff;
      newest_in   = newest_ff;
      oldest_in   = oldest_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      acc_in      = acc_ff;
      hits_in     = hits_ff;
      faults_in   = faults_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      size_in     = size_ff;
      cnt_in      = cnt_ff;
      ok_in       = ok_ff;
      hit_in      = hit_ff;
      ins_in      = ins_ff;
      ev_in       = ev_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      last_in     = last_ff;
      cur_in      = cur_ff;
      drop_in     = drop_ff;
      upd0_in     = upd0_ff;
      upd1_in     = upd1_ff;
      ent_we      = 1'b0;
      ent_waddr   = cur_ff;
      ent_wdata   = '{key: key_ff, size: size_ff};
      ent_raddr   = cur_ff;
      lnk_we      = 1'b0;
      lnk_waddr   = upd0_ff.slot;
      lnk_raddr   = cur_ff;
      lnk_wdata   = lnk_rdata;
      if (upd0_ff.sel == LINK_NEWER) begin
         lnk_wdata.newer = upd0_ff.value;
      end else begin
         lnk_wdata.older = upd0_ff.value;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_data.operation;
               key_in  = req_data.key[KEY_BITS-1:0];
               size_in = req_data.entry_size;
               cnt_in  = req_data.evict_count;
               ok_in   = 1'b0;
               hit_in  = 1'b0;
               ins_in  = 1'b0;
               ev_in   = '0;
               idx_in  = '0;
               pend_in = 1'b0;
               state_in = ST_DONE;
               case (req_data.operation)
                  OP_ACCESS: begin
                     acc_in = sat_inc(acc_ff);
                     if (req_data.key[KEY_BITS-1:0] != '0) begin
                        ok_in    = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_TOUCH, OP_REMOVE: begin
                     if (req_data.key[KEY_BITS-1:0] != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_EVICT: begin
                     if (COUNT_BITS'(req_data.evict_count) <= count_ff) begin
                        ok_in    = 1'b1;
                        state_in = ST_EVICT3;
                     end
                  end
                  OP_CLEAR: begin
                     acc_in    = '0;
                     hits_in   = '0;
                     faults_in = '0;
                     ok_in     = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // issue one key read per cycle, compare the one issued before
         ST_SCAN: begin
            if (match) begin
               cur_in = last_ff;
               case (op_ff)
                  OP_ACCESS: begin
                     hit_in  = 1'b1;
                     hits_in = sat_inc(hits_ff);
                     drop_in = 1'b0;
                     state_in = (last_ff == newest_ff) ? ST_DONE : ST_UNL_RD;
                  end
                  OP_TOUCH: begin
                     ok_in   = 1'b1;
                     drop_in = 1'b0;
                     state_in = (last_ff == newest_ff) ? ST_DONE : ST_UNL_RD;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     ev_in    = 7'd1;
                     drop_in  = 1'b1;
                     state_in = ST_UNL_RD;
                  end
               endcase
            end else if (idx_ff == COUNT_BITS'(ENTRIES)) begin
               if (op_ff == OP_ACCESS) begin
                  faults_in = sat_inc(faults_ff);
                  state_in  = ST_EVICT;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               ent_raddr = idx_ff[SLOT_BITS-1:0];
               last_in   = idx_ff[SLOT_BITS-1:0];
               pend_in   = 1'b1;
               idx_in    = idx_ff + COUNT_BITS'(1);
            end
         end

         ST_UNL_RD: begin
            ent_raddr = cur_ff;
            lnk_raddr = cur_ff;
            state_in  = ST_UNL_DO;
         end

         ST_UNL_DO: begin
            upd0_in.valid = 1'b0;
            upd1_in.valid = 1'b0;
            if (cur_ff == newest_ff && cur_ff == oldest_ff) begin
               // sole entry: list ends stay as they are
            end else if (cur_ff == newest_ff) begin
               newest_in = lnk_rdata.older;
            end else if (cur_ff == oldest_ff) begin
               oldest_in = lnk_rdata.newer;
            end else begin
               upd0_in = '{valid: 1'b1, slot: lnk_rdata.older, sel: LINK_NEWER,
                           value: lnk_rdata.newer};
               upd1_in = '{valid: 1'b1, slot: lnk_rdata.newer, sel: LINK_OLDER,
                           value: lnk_rdata.older};
            end
            if (drop_ff) begin
               valid_in[cur_ff] = 1'b0;
               count_in = count_ff - COUNT_BITS'(1);
               used_in  = used_ff - ent_rdata.size;
            end
            ret_in   = ST_POST;
            state_in = (cur_ff != newest_ff && cur_ff != oldest_ff) ? ST_LNK_RD : ST_POST;
         end

         ST_POST: begin
            if (!drop_ff) begin
               upd0_in   = '{valid: 1'b1, slot: cur_ff, sel: LINK_OLDER, value: newest_ff};
               upd1_in   = '{valid: 1'b1, slot: newest_ff, sel: LINK_NEWER, value: cur_ff};
               newest_in = cur_ff;
               ret_in    = ST_DONE;
               state_in  = ST_LNK_RD;
            end else begin
               case (op_ff)
                  OP_ACCESS: state_in = ST_EVICT;
                  OP_EVICT:  state_in = ST_EVICT3;
                  default:   state_in = ST_DONE;
               endcase
            end
         end

         ST_LNK_RD: begin
            lnk_raddr = upd0_ff.slot;
            state_in  = ST_LNK_WR;
         end

         // merge the new field into the word read and write it back
         ST_LNK_WR: begin
            lnk_we        = 1'b1;
            upd0_in       = upd1_ff;
            upd1_in.valid = 1'b0;
            state_in      = upd1_ff.valid ? ST_LNK_RD : ret_ff;
         end

         ST_EVICT: begin
            if (count_ff != '0 && (!fits || count_ff >= COUNT_BITS'(ENTRIES))) begin
               cur_in   = oldest_ff;
               drop_in  = 1'b1;
               ev_in    = ev_ff + 7'd1;
               state_in = ST_UNL_RD;
            end else if (fits) begin
               idx_in   = '0;
               state_in = ST_FREE;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_EVICT3: begin
            if (ev_ff < cnt_ff && count_ff != '0) begin
               cur_in   = oldest_ff;
               drop_in  = 1'b1;
               ev_in    = ev_ff + 7'd1;
               state_in = ST_UNL_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_FREE: begin
            if (!valid_ff[idx_ff[SLOT_BITS-1:0]]) begin
               cur_in   = idx_ff[SLOT_BITS-1:0];
               state_in = ST_INSERT;
            end else begin
               idx_in = idx_ff + COUNT_BITS'(1);
            end
         end

         ST_INSERT: begin
            ent_we           = 1'b1;
            valid_in[cur_ff] = 1'b1;
            count_in         = count_ff + COUNT_BITS'(1);
            used_in          = used_ff + size_ff;
            ins_in           = 1'b1;
            newest_in        = cur_ff;
            if (count_ff == '0) begin
               oldest_in = cur_ff;
               state_in  = ST_DONE;
            end else begin
               upd0_in  = '{valid: 1'b1, slot: cur_ff, sel: LINK_OLDER, value: newest_ff};
               upd1_in  = '{valid: 1'b1, slot: newest_ff, sel: LINK_NEWER, value: cur_ff};
               ret_in   = ST_DONE;
               state_in = ST_LNK_RD;
            end
         end

         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{ok: ok_ff, hit: hit_ff, inserted: ins_ff,
                                evicted_total: ev_ff, used_size: used_ff,
                                access_total: acc_ff, hit_total: hits_ff,
                                fault_total: faults_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         capacity_ff  <= '0;
         valid_ff     <= '0;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         count_ff     <= '0;
         used_ff      <= '0;
         acc_ff       <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         upd0_ff      <= '0;
         upd1_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         capacity_ff  <= capacity_in;
         valid_ff     <= valid_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         acc_ff       <= acc_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
         upd0_ff      <= upd0_in;
         upd1_ff      <= upd1_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      size_ff     <= size_in;
      cnt_ff      <= cnt_in;
      ok_ff       <= ok_in;
      hit_ff      <= hit_in;
      ins_ff      <= ins_in;
      ev_ff       <= ev_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      last_ff     <= last_in;
      cur_ff      <= cur_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SALC_ASSERT(a_count_matches_valid, $countones(valid_ff) == 32'(count_ff), "count != valid bits")
   `SALC_NEVER(a_count_bound, count_ff > COUNT_BITS'(ENTRIES), "occupied count above entries")
   `SALC_ASSERT(a_insert_has_room, state_ff == ST_INSERT |-> count_ff < COUNT_BITS'(ENTRIES) && !valid_ff[cur_ff], "insert into full cache or used slot")
   `SALC_ASSERT(a_link_write_pending, state_ff == ST_LNK_WR |-> upd0_ff.valid, "link write without pending update")

endmodule
